@@ rtl/core/rmf_pkg.sv @@
// Shared types and constants of the running median filter.
package rmf_pkg;

	localparam int WLEN_W     = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURN_IN       = 1'd1;

	localparam logic [WLEN_W-1:0] WLEN_RESET    = 6'd5;
	localparam logic              BURN_IN_RESET = 1'b1;

	typedef struct packed {
		logic load_in;
		logic fill_wr;
		logic srch_rd;
		logic set_pos;
		logic rd_dn;
		logic rd_up;
		logic shift_dn;
		logic shift_up;
		logic place;
		logic out_load;
		logic out_prime;
		logic adv_ws;
	} cmd_t;

	typedef struct packed {
		logic primed;
		logic fill_last;
		logic match;
		logic p_zero;
		logic p_top;
		logic less;
		logic greater;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/running_median_filter.sv @@
// Top level: sliding-window median filter; config registers, sequencer and datapath.
// Window L: the priming sample is accepted, fills all L slots, then goes to the output load.
// Later samples: accept, rank search for the written slot, walk down or up to its rank, place,
// median read, output load; one memory read port paces it.
// One sample in work at a time; a finished result waits in the output register (stalls in OUT or POUT).
// Reset: window_length 5, burn_in 1, filter unprimed; any config write also unprimes it.
module running_median_filter #(
	parameter int MAX_WINDOW   = 32,
	parameter int SAMPLE_WIDTH = 16,
	localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [DATA_W-1:0]                 s_tdata,   // [SAMPLE_WIDTH-1:0] sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [DATA_W-1:0]                 m_tdata,   // [SAMPLE_WIDTH-1:0] median
	input  logic                              cfg_we,
	input  logic [rmf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_WINDOW + 1);
	localparam int RW = (CW > rmf_pkg::WLEN_W) ? CW : rmf_pkg::WLEN_W;

	logic [rmf_pkg::WLEN_W-1:0]     window_length_q;
	logic                           burn_in_q;
	logic [RW-1:0]                  req;
	logic [RW-1:0]                  clamped;
	logic [RW-1:0]                  odd_len;
	logic [CW-1:0]                  len;
	logic signed [SAMPLE_WIDTH-1:0] median;
	rmf_pkg::cmd_t                  cmd;
	rmf_pkg::sts_t                  sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= rmf_pkg::WLEN_RESET;
			burn_in_q       <= rmf_pkg::BURN_IN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmf_pkg::REG_WINDOW_LENGTH: window_length_q <= cfg_data[rmf_pkg::WLEN_W-1:0];
				rmf_pkg::REG_BURN_IN:       burn_in_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp to max, then force odd
	always_comb begin
		req     = RW'(window_length_q);
		clamped = (req > RW'(MAX_WINDOW)) ? RW'(MAX_WINDOW) : req;
		if (!clamped[0])
			odd_len = (clamped == RW'(MAX_WINDOW)) ? clamped - 1'b1 : clamped + 1'b1;
		else
			odd_len = clamped;
		len = CW'(odd_len);
	end

	rmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmf_dpath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (signed'(s_tdata[SAMPLE_WIDTH-1:0])),
		.burn_in  (burn_in_q),
		.len      (len),
		.cfg_clr  (cfg_we),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.median   (median)
	);

	assign m_tdata = DATA_W'($unsigned(median));

endmodule

@@ rtl/core/rmf_ctrl.sv @@
// Sequencer of the running median filter: priming sweep, rank search, insertion walk.
module rmf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  rmf_pkg::sts_t sts,
	output rmf_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FILL   = 4'd1;
	localparam logic [3:0] ST_POUT   = 4'd2;
	localparam logic [3:0] ST_SRCH   = 4'd3;
	localparam logic [3:0] ST_DN_RD  = 4'd4;
	localparam logic [3:0] ST_DN_CMP = 4'd5;
	localparam logic [3:0] ST_UP_RD  = 4'd6;
	localparam logic [3:0] ST_UP_CMP = 4'd7;
	localparam logic [3:0] ST_PLACE  = 4'd8;
	localparam logic [3:0] ST_MED_RD = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       moved_q;
	logic       moved_nxt;

	always_comb begin
		state_nxt = state_q;
		moved_nxt = moved_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = sts.primed ? ST_SRCH : ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.fill_last)
					state_nxt = ST_POUT;
			end
			ST_POUT: begin
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_prime = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			ST_SRCH: begin
				if (sts.match) begin
					cmd.set_pos = 1'b1;
					moved_nxt   = 1'b0;
					state_nxt   = ST_DN_RD;
				end else begin
					cmd.srch_rd = 1'b1;
				end
			end
			ST_DN_RD: begin
				if (sts.p_zero) begin
					state_nxt = moved_q ? ST_PLACE : ST_UP_RD;
				end else begin
					cmd.rd_dn = 1'b1;
					state_nxt = ST_DN_CMP;
				end
			end
			ST_DN_CMP: begin
				if (sts.less) begin
					cmd.shift_dn = 1'b1;
					moved_nxt    = 1'b1;
					state_nxt    = ST_DN_RD;
				end else begin
					state_nxt = moved_q ? ST_PLACE : ST_UP_RD;
				end
			end
			ST_UP_RD: begin
				if (sts.p_top) begin
					state_nxt = ST_PLACE;
				end else begin
					cmd.rd_up = 1'b1;
					state_nxt = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (sts.greater) begin
					cmd.shift_up = 1'b1;
					state_nxt    = ST_UP_RD;
				end else begin
					state_nxt = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_nxt = ST_MED_RD;
			end
			ST_MED_RD: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.adv_ws   = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			moved_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			moved_q <= moved_nxt;
		end
	end

endmodule

@@ rtl/core/rmf_dpath.sv @@
// Datapath of the running median filter: rank and value memories, pointers, output register.
module rmf_dpath #(
	parameter int MAX_WINDOW   = 32,
	parameter int SAMPLE_WIDTH = 16,
	localparam int IW = $clog2(MAX_WINDOW),
	localparam int CW = $clog2(MAX_WINDOW + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rmf_pkg::cmd_t                  cmd,
	output rmf_pkg::sts_t                  sts,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           burn_in,
	input  logic [CW-1:0]                  len,
	input  logic                           cfg_clr,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic signed [SAMPLE_WIDTH-1:0] median
);

	// rank position -> slot, and rank position -> sample value
	logic [IW-1:0]                  rank_mem [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] val_mem  [MAX_WINDOW];

	logic [IW-1:0]                  rd_rank_q;
	logic signed [SAMPLE_WIDTH-1:0] rd_val_q;
	logic [IW-1:0]                  raddr;
	logic                           we;
	logic [IW-1:0]                  waddr;
	logic [IW-1:0]                  wrank;
	logic signed [SAMPLE_WIDTH-1:0] wval;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] fill;
	logic [IW-1:0]                  ws_q;
	logic [IW-1:0]                  cnt_q;
	logic [IW-1:0]                  p_q;
	logic [IW-1:0]                  addr_s1;
	logic                           chk_s1;
	logic                           primed_q;
	logic                           m_tvalid_q;
	logic signed [SAMPLE_WIDTH-1:0] median_q;
	logic [IW-1:0]                  mid;
	logic [IW-1:0]                  last;
	logic [CW-1:0]                  ws_inc;

	assign fill   = burn_in ? x_q : '0;
	assign mid    = IW'(len >> 1);
	assign last   = IW'(len - 1'b1);
	assign ws_inc = CW'(ws_q) + 1'b1;

	always_comb begin
		if (cmd.srch_rd)
			raddr = cnt_q;
		else if (cmd.rd_dn)
			raddr = p_q - 1'b1;
		else if (cmd.rd_up)
			raddr = p_q + 1'b1;
		else
			raddr = mid;
	end

	always_comb begin
		we    = 1'b0;
		waddr = p_q;
		wrank = rd_rank_q;
		wval  = rd_val_q;
		if (cmd.fill_wr) begin
			we    = 1'b1;
			waddr = cnt_q;
			wrank = cnt_q;
			wval  = fill;
		end else if (cmd.shift_dn || cmd.shift_up) begin
			we = 1'b1;
		end else if (cmd.place) begin
			we    = 1'b1;
			wrank = ws_q;
			wval  = x_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rank_mem[waddr] <= wrank;
			val_mem[waddr]  <= wval;
		end
		rd_rank_q <= rank_mem[raddr];
		rd_val_q  <= val_mem[raddr];
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		if (cmd.load_in)
			x_q <= sample;
		if (cmd.load_in)
			cnt_q <= '0;
		else if (cmd.fill_wr || cmd.srch_rd)
			cnt_q <= cnt_q + 1'b1;
		if (cmd.set_pos)
			p_q <= addr_s1;
		else if (cmd.shift_dn)
			p_q <= p_q - 1'b1;
		else if (cmd.shift_up)
			p_q <= p_q + 1'b1;
		if (cmd.out_load)
			median_q <= cmd.out_prime ? fill : rd_val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1     <= 1'b0;
			primed_q   <= 1'b0;
			ws_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			chk_s1 <= cmd.srch_rd;
			if (cfg_clr) begin
				primed_q <= 1'b0;
				ws_q     <= '0;
			end else if (cmd.out_load && cmd.out_prime) begin
				primed_q <= 1'b1;
			end else if (cmd.adv_ws) begin
				ws_q <= (ws_inc == len) ? '0 : IW'(ws_inc);
			end
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign sts.primed    = primed_q;
	assign sts.fill_last = (cnt_q == last);
	assign sts.match     = chk_s1 && (rd_rank_q == ws_q);
	assign sts.p_zero    = (p_q == '0);
	assign sts.p_top     = ((CW'(p_q) + 1'b1) >= len);
	assign sts.less      = (x_q < rd_val_q);
	assign sts.greater   = (x_q > rd_val_q);
	assign sts.out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign median   = median_q;

endmodule

@@ tb/tb_running_median_filter.sv @@
// Testbench for running_median_filter: queued stream driver, checking monitor, median predictor.
`timescale 1ns / 100ps

module tb_running_median_filter;

	localparam int MAX_WIN   = 32;
	localparam int SW        = 16;
	localparam int ITEMS     = 1300;
	localparam int CALM_AT   = 1150;
	localparam int HOLD_AT   = 500;
	localparam int HOLD_LEN  = 600;
	localparam int LIMIT     = 600000;
	localparam int CIW       = rmf_pkg::CFG_IDX_W;
	localparam int CDW       = rmf_pkg::CFG_DATA_W;
	localparam int WLW       = rmf_pkg::WLEN_W;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [SW-1:0]         s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [SW-1:0]         m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CIW-1:0]        cfg_index = '0;
	logic [CDW-1:0]        cfg_data  = '0;

	running_median_filter #(
		.MAX_WINDOW  (MAX_WIN),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state
	logic signed [SW-1:0] win_store [MAX_WIN];
	logic [4:0]           rank_list [MAX_WIN];
	int                   wr_slot  = 0;
	bit                   primed   = 1'b0;
	logic [WLW-1:0]       wlen_reg = rmf_pkg::WLEN_RESET;
	logic                 burn_reg = rmf_pkg::BURN_IN_RESET;

	logic [SW-1:0] pend_q [$];
	logic [SW-1:0] median_q [$];
	int            n_pushed  = 0;
	int            n_sent    = 0;
	int            n_results = 0;
	int            err_cnt   = 0;
	int            cycle_cnt = 0;
	bit            idle_en   = 1'b1;

	int            tx_gap = 0;
	int            rx_gap = 0;
	int            hold_cnt = 0;
	bit            hold_done = 1'b0;
	logic          tx_valid_nxt;
	logic [SW-1:0] tx_data_nxt;
	logic [SW-1:0] med_calc;
	logic [SW-1:0] med_exp;

	function automatic int eff_len(logic [WLW-1:0] wl);
		int n;
		n = (wl > MAX_WIN) ? MAX_WIN : int'(wl);
		if (n % 2 == 0)
			n = (n == MAX_WIN) ? n - 1 : n + 1;
		return n;
	endfunction

	task automatic median_predict(input logic signed [SW-1:0] x, output logic [SW-1:0] med);
		int len, ws, pos, p;
		bit moved;
		logic signed [SW-1:0] fill;
		len = eff_len(wlen_reg);
		if (!primed) begin
			fill = burn_reg ? x : '0;
			for (int i = 0; i < len; i++) begin
				win_store[i] = fill;
				rank_list[i] = i[4:0];
			end
			primed  = 1'b1;
			wr_slot = 0;
			med     = fill;
		end else begin
			ws  = wr_slot % len;
			pos = len;
			win_store[ws] = x;
			for (int i = 0; i < len; i++)
				if (rank_list[i] == ws && pos == len)
					pos = i;
			if (pos < len) begin
				moved = 1'b0;
				p = pos;
				while (p > 0 && x < win_store[rank_list[p-1]]) begin
					rank_list[p]   = rank_list[p-1];
					rank_list[p-1] = ws[4:0];
					p--;
					moved = 1'b1;
				end
				if (!moved) begin
					p = pos;
					while (p + 1 < len && x > win_store[rank_list[p+1]]) begin
						rank_list[p]   = rank_list[p+1];
						rank_list[p+1] = ws[4:0];
						p++;
					end
				end
			end
			med     = win_store[rank_list[len/2]];
			wr_slot = (ws + 1) % len;
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("tb_running_median_filter: errors");
			$finish;
		end
	end

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_gap   <= 0;
			n_sent   <= 0;
		end else begin
			tx_valid_nxt = s_tvalid;
			tx_data_nxt  = s_tdata;
			if (s_tvalid && s_tready) begin
				median_predict(s_tdata, med_calc);
				median_q.push_back(med_calc);
				n_sent <= n_sent + 1;
				tx_valid_nxt = 1'b0;
			end
			if (!tx_valid_nxt) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
				end else if (idle_en && $urandom_range(0, 7) == 0) begin
					tx_gap <= $urandom_range(0, 8);
				end else if (pend_q.size() != 0) begin
					tx_data_nxt  = pend_q.pop_front();
					tx_valid_nxt = 1'b1;
				end
			end
			s_tvalid <= tx_valid_nxt;
			s_tdata  <= tx_data_nxt;
		end
	end

	// median monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_gap    <= 0;
			hold_cnt  <= 0;
			hold_done <= 1'b0;
			n_results <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results <= n_results + 1;
				if (median_q.size() == 0) begin
					$error("median: unexpected transaction, actual %0d", $signed(m_tdata));
					err_cnt++;
				end else begin
					med_exp = median_q.pop_front();
					if (m_tdata !== med_exp) begin
						$error("median: expected %0d, actual %0d",
							$signed(med_exp), $signed(m_tdata));
						err_cnt++;
					end
				end
			end
			if (!hold_done && n_sent >= HOLD_AT && pend_q.size() > 2) begin
				hold_done <= 1'b1;
				hold_cnt  <= HOLD_LEN;
				m_tready  <= 1'b0;
			end else if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap   <= rx_gap - 1;
				m_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				rx_gap   <= $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic cfg_write(input logic [CIW-1:0] idx, input logic [CDW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == rmf_pkg::REG_WINDOW_LENGTH)
			wlen_reg = val;
		else if (idx == rmf_pkg::REG_BURN_IN)
			burn_reg = val[0];
		primed  = 1'b0;
		wr_slot = 0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(input logic [SW-1:0] v);
		pend_q.push_back(v);
		n_pushed++;
	endtask

	task automatic wait_drain();
		do
			@(posedge clk);
		while (n_results != n_pushed);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int total;
		int n_items;
		int r;
		int ramp;
		int step;
		logic [WLW-1:0] wl;
		logic [SW-1:0] v;
		logic [SW-1:0] ext [4];

		ext = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
		ramp = 0;
		step = 1;
		total = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: length 5, burn-in on
		@(negedge clk);
		push_sample(16'h7fff); push_sample(16'h8000); push_sample(16'h0000);
		push_sample(16'hffff); push_sample(16'h0001); push_sample(16'h7fff);
		push_sample(16'h8000); push_sample(16'h8000); push_sample(16'h7fff);
		push_sample(16'h0000);
		wait_drain();

		// length 0 gives a window of one; priming sample dropped without burn-in
		cfg_write(rmf_pkg::REG_WINDOW_LENGTH, 6'd0);
		cfg_write(rmf_pkg::REG_BURN_IN, 6'd0);
		@(negedge clk);
		push_sample(16'd1234); push_sample(-16'sd5); push_sample(16'd7);
		wait_drain();

		// oversized request clamps to 31
		cfg_write(rmf_pkg::REG_WINDOW_LENGTH, 6'd63);
		cfg_write(rmf_pkg::REG_BURN_IN, 6'b111111);
		@(negedge clk);
		push_sample(16'h8000); push_sample(16'h7fff); push_sample(16'h7fff);
		push_sample(16'd5);
		wait_drain();

		// even request at the maximum is lowered
		cfg_write(rmf_pkg::REG_WINDOW_LENGTH, 6'd32);
		cfg_write(rmf_pkg::REG_BURN_IN, 6'b101010);
		@(negedge clk);
		push_sample(16'd100); push_sample(-16'sd100);
		wait_drain();

		// even request is raised; equal values
		cfg_write(rmf_pkg::REG_WINDOW_LENGTH, 6'd2);
		@(negedge clk);
		push_sample(16'd3); push_sample(16'd3); push_sample(16'd2); push_sample(16'd4);
		wait_drain();

		while (total < ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				case ($urandom_range(0, 5))
					0: wl = 6'd0;
					1: wl = 6'd1;
					2: wl = 6'd31;
					3: wl = 6'd32;
					4: wl = 6'd33;
					default: wl = 6'd63;
				endcase
			else
				wl = WLW'($urandom_range(0, 63));
			case ($urandom_range(0, 3))
				0: cfg_write(rmf_pkg::REG_WINDOW_LENGTH, wl);
				1: cfg_write(rmf_pkg::REG_BURN_IN, CDW'($urandom_range(0, 63)));
				2: begin
					cfg_write(rmf_pkg::REG_WINDOW_LENGTH, wl);
					cfg_write(rmf_pkg::REG_BURN_IN, CDW'($urandom_range(0, 63)));
				end
				default: ;
			endcase
			n_items = $urandom_range(15, 90);
			@(negedge clk);
			idle_en = (total < CALM_AT) && ($urandom_range(0, 3) != 0);
			repeat (n_items) begin
				r = $urandom_range(0, 9);
				if (r <= 3) begin
					v = SW'($urandom);
				end else if (r <= 5) begin
					v = SW'($urandom_range(0, 6) - 3);
				end else if (r == 6) begin
					v = ext[$urandom_range(0, 3)];
				end else begin
					if ($urandom_range(0, 15) == 0)
						step = $urandom_range(0, 128) - 64;
					ramp = ramp + step;
					v = ramp[SW-1:0];
				end
				push_sample(v);
			end
			total += n_items;
			wait_drain();
		end

		repeat (120) @(posedge clk);
		if (median_q.size() != 0) begin
			$error("median: %0d expected transactions never arrived", median_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("tb_running_median_filter: clean");
		else
			$display("tb_running_median_filter: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/rmf_pkg.sv
rtl/core/rmf_ctrl.sv
rtl/core/rmf_dpath.sv
rtl/core/running_median_filter.sv
tb/tb_running_median_filter.sv
